>>> design/rhpc_pkg.sv
`default_nettype none

package rhpc_pkg;

    localparam int unsigned RHPC_MAX_PATTERN = 256;
    localparam int unsigned HASH_W           = 31;
    localparam int unsigned SYM_W            = 8;
    localparam int unsigned COUNT_W          = 32;

    localparam logic [HASH_W-1:0]  MULT_RESET = HASH_W'(131);
    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;

    // Stage one to stage two: what the hash stage must do with one word
    typedef struct packed {
        logic             text;        // text byte, else pattern byte
        logic             text_first;  // text byte that opens a new text
        logic             active;      // text byte taken into the window
        logic             subtract;    // window already full, drop oldest byte
        logic             full;        // window full after this byte
        logic             overflow;    // pattern byte rejected
        logic [SYM_W-1:0] symbol;
    } stage_t;

    typedef struct packed {
        logic               overflow;
        logic               window_full;
        logic [COUNT_W-1:0] match_count;
        logic               match;
    } result_t;

    // Product modulo 2^31: only the low half of the product is kept
    function automatic logic [HASH_W-1:0] mul_mod(input logic [HASH_W-1:0] a,
                                                  input logic [HASH_W-1:0] b);
        logic [2*HASH_W-1:0] prod;
        prod = a * b;
        return prod[HASH_W-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/rolling_hash_pattern_counter_unit.sv
// Channel   Ports                          Contents (low bit first)
// -------   ----------------------------   ---------------------------------------
// input     s_tvalid s_tready s_tdata      tdata: symbol[7:0]
//           s_tuser                        tuser: mode[0], first[1]
// result    m_tvalid m_tready m_tdata      tdata: match[0], match_count[32:1],
//                                                 window_full[33], overflow[34]
// config    cfg_we cfg_wdata               hash multiplier, 31 bits
//
// One word per cycle while the result is not stalled; stage one registers each word, stage two its result.
// Stage one updates the pattern hash, fill count and ring pointer and reads and writes the ring store;
// stage two folds in the byte leaving the window and registers the result.
// The window hash loop is one 31x31 multiply-add per cycle and sets the clock.
// Reset (aresetn low, synchronous) empties the pipe, clears pattern and text state and
// loads multiplier 131; the ring store keeps no reset. A stalled result holds the pipe.
`default_nettype none

module rolling_hash_pattern_counter_unit
    import rhpc_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = RHPC_MAX_PATTERN
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    // input words
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [7:0]        s_tdata,   // symbol[7:0]
    input  wire logic [1:0]        s_tuser,   // mode[0], first[1]
    // result words
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic      [39:0]       m_tdata,   // match, match_count, window_full, overflow
    // multiplier register
    input  wire logic              cfg_we,
    input  wire logic [HASH_W-1:0] cfg_wdata
);

    localparam int unsigned PTR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int unsigned LEN_W = $clog2(MAX_PATTERN + 1);

    logic [HASH_W-1:0] mult_reg;
    logic              accept, advance, s1_valid;
    stage_t            s1;
    logic              mem_wr_en;
    logic [PTR_W-1:0]  mem_addr;
    logic [SYM_W-1:0]  old_symbol;
    logic [HASH_W-1:0] pattern_hash, multiplier_power;
    result_t           result;

    // Hold the multiplier; the user must write it only while the pipe is idle, the block does not enforce this
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mult_reg <= MULT_RESET;
        end else if (cfg_we) begin
            mult_reg <= cfg_wdata;
        end
    end

    // Take a word whenever stage one is empty or moving on
    assign s_tready = !s1_valid || advance;
    assign accept   = s_tvalid && s_tready;

    rhpc_ctrl #(
        .MAX_PATTERN (MAX_PATTERN),
        .PTR_W       (PTR_W),
        .LEN_W       (LEN_W)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .accept           (accept),
        .advance          (advance),
        .mode             (s_tuser[0]),
        .first            (s_tuser[1]),
        .symbol           (s_tdata),
        .multiplier       (mult_reg),
        .s1_valid         (s1_valid),
        .s1               (s1),
        .mem_wr_en        (mem_wr_en),
        .mem_addr         (mem_addr),
        .pattern_hash     (pattern_hash),
        .multiplier_power (multiplier_power)
    );

    // Read the leaving byte and write the new one at the same slot
    rhpc_ring_mem #(
        .DEPTH  (MAX_PATTERN),
        .ADDR_W (PTR_W)
    ) u_ring (
        .aclk    (aclk),
        .rd_en   (accept),
        .wr_en   (mem_wr_en),
        .addr    (mem_addr),
        .wr_data (s_tdata),
        .rd_data (old_symbol)
    );

    rhpc_window u_window (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s1_valid         (s1_valid),
        .s1               (s1),
        .old_symbol       (old_symbol),
        .multiplier       (mult_reg),
        .pattern_hash     (pattern_hash),
        .multiplier_power (multiplier_power),
        .out_ready        (m_tready),
        .advance          (advance),
        .out_valid        (m_tvalid),
        .out_result       (result)
    );

    assign m_tdata = {5'b0, result};

endmodule

`default_nettype wire

>>> design/rhpc_ring_mem.sv
`default_nettype none

module rhpc_ring_mem
    import rhpc_pkg::*;
#(
    parameter int unsigned DEPTH  = RHPC_MAX_PATTERN,
    parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              rd_en,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] addr,
    input  wire logic [SYM_W-1:0]  wr_data,
    output logic      [SYM_W-1:0]  rd_data
);

    logic [SYM_W-1:0] mem [DEPTH];

    // Read first: a read and write of the same entry returns the old byte
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[addr];
        end
    end

endmodule

`default_nettype wire

>>> design/rhpc_ctrl.sv
`default_nettype none

module rhpc_ctrl
    import rhpc_pkg::*;
#(
    parameter int unsigned MAX_PATTERN = RHPC_MAX_PATTERN,
    parameter int unsigned PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1,
    parameter int unsigned LEN_W       = $clog2(MAX_PATTERN + 1)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              accept,
    input  wire logic              advance,
    input  wire logic              mode,
    input  wire logic              first,
    input  wire logic [SYM_W-1:0]  symbol,
    input  wire logic [HASH_W-1:0] multiplier,
    output logic                   s1_valid,
    output stage_t                 s1,
    output logic                   mem_wr_en,
    output logic      [PTR_W-1:0]  mem_addr,
    output logic      [HASH_W-1:0] pattern_hash,
    output logic      [HASH_W-1:0] multiplier_power
);

    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(MAX_PATTERN);

    logic              s1_valid_reg, s1_valid_next;
    stage_t            s1_reg, s1_next;
    logic [HASH_W-1:0] phash_reg, phash_next;
    logic [HASH_W-1:0] power_reg, power_next;
    logic [LEN_W-1:0]  length_reg, length_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [PTR_W-1:0]  ptr_reg, ptr_next;

    logic [HASH_W-1:0] base_hash, base_power;
    logic [LEN_W-1:0]  base_len, base_fill, fill_inc, ptr_inc;
    logic [PTR_W-1:0]  base_ptr, rd_ptr;

    always_comb begin
        base_hash  = first ? '0 : phash_reg;
        base_power = first ? HASH_W'(1) : power_reg;
        base_len   = first ? '0 : length_reg;
        base_fill  = first ? '0 : fill_reg;
        base_ptr   = first ? '0 : ptr_reg;
        rd_ptr     = (LEN_W'(base_ptr) >= length_reg) ? '0 : base_ptr;
        ptr_inc    = LEN_W'(rd_ptr) + LEN_W'(1);
        fill_inc   = base_fill + LEN_W'(1);

        phash_next  = phash_reg;
        power_next  = power_reg;
        length_next = length_reg;
        fill_next   = fill_reg;
        ptr_next    = ptr_reg;
        mem_wr_en   = 1'b0;

        s1_next            = '0;
        s1_next.text       = mode;
        s1_next.text_first = mode & first;
        s1_next.symbol     = symbol;

        if (!mode) begin
            // Pattern byte: extend the pattern hash unless it is at capacity, empty the text window
            phash_next  = base_hash;
            power_next  = base_power;
            length_next = base_len;
            if (base_len < LEN_CAP) begin
                phash_next  = mul_mod(base_hash, multiplier) + HASH_W'(symbol);
                power_next  = mul_mod(base_power, multiplier);
                length_next = base_len + LEN_W'(1);
            end else begin
                s1_next.overflow = 1'b1;
            end
            fill_next = '0;
            ptr_next  = '0;
        end else if (length_reg != '0) begin
            s1_next.active   = 1'b1;
            s1_next.subtract = base_fill >= length_reg;
            fill_next        = s1_next.subtract ? base_fill : fill_inc;
            s1_next.full     = fill_next >= length_reg;
            ptr_next         = (ptr_inc >= length_reg) ? '0 : ptr_inc[PTR_W-1:0];
            mem_wr_en        = accept;
        end else begin
            // Empty pattern: drop the byte, keep only the text restart
            fill_next = base_fill;
            ptr_next  = base_ptr;
        end

        if (accept) begin
            s1_valid_next = 1'b1;
        end else if (advance) begin
            s1_valid_next = 1'b0;
        end else begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            phash_reg    <= '0;
            power_reg    <= HASH_W'(1);
            length_reg   <= '0;
            fill_reg     <= '0;
            ptr_reg      <= '0;
        end else begin
            s1_valid_reg <= s1_valid_next;
            if (accept) begin
                phash_reg  <= phash_next;
                power_reg  <= power_next;
                length_reg <= length_next;
                fill_reg   <= fill_next;
                ptr_reg    <= ptr_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_reg <= s1_next;
        end
    end

    assign s1_valid         = s1_valid_reg;
    assign s1               = s1_reg;
    assign mem_addr         = rd_ptr;
    assign pattern_hash     = phash_reg;
    assign multiplier_power = power_reg;

endmodule

`default_nettype wire

>>> design/rhpc_window.sv
`default_nettype none

module rhpc_window
    import rhpc_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s1_valid,
    input  wire stage_t            s1,
    input  wire logic [SYM_W-1:0]  old_symbol,
    input  wire logic [HASH_W-1:0] multiplier,
    input  wire logic [HASH_W-1:0] pattern_hash,
    input  wire logic [HASH_W-1:0] multiplier_power,
    input  wire logic              out_ready,
    output logic                   advance,
    output logic                   out_valid,
    output result_t                out_result
);

    logic               out_valid_reg;
    result_t            result_reg, result_next;
    logic [HASH_W-1:0]  whash_reg, whash_next;
    logic [COUNT_W-1:0] matches_reg, matches_next;

    logic [HASH_W-1:0]  base_hash, rolled, leaving;
    logic [COUNT_W-1:0] base_matches;
    logic               hit;

    always_comb begin
        advance      = !out_valid_reg || out_ready;
        base_hash    = s1.text_first ? '0 : whash_reg;
        base_matches = s1.text_first ? '0 : matches_reg;
        leaving      = mul_mod(HASH_W'(old_symbol), multiplier_power);
        rolled       = mul_mod(base_hash, multiplier) + HASH_W'(s1.symbol)
                       - (s1.subtract ? leaving : '0);
        hit          = s1.active && s1.full && (rolled == pattern_hash);

        result_next  = '0;
        whash_next   = whash_reg;
        matches_next = matches_reg;

        if (!s1.text) begin
            whash_next           = '0;
            result_next.overflow = s1.overflow;
        end else if (s1.active) begin
            whash_next              = rolled;
            matches_next            = (hit && base_matches != COUNT_MAX) ?
                                      base_matches + COUNT_W'(1) : base_matches;
            result_next.match       = hit;
            result_next.window_full = s1.full;
        end else begin
            whash_next   = base_hash;
            matches_next = base_matches;
        end
        result_next.match_count = matches_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            whash_reg     <= '0;
            matches_reg   <= '0;
        end else if (advance) begin
            out_valid_reg <= s1_valid;
            if (s1_valid) begin
                whash_reg   <= whash_next;
                matches_reg <= matches_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && s1_valid) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_result = result_reg;

endmodule

`default_nettype wire

>>> design/rhpc_checker.sv
`default_nettype none

module rhpc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata
);

    // A stalled result word holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // A match only comes from a full window and with a nonzero count
    a_match_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[33] && (m_tdata[32:1] != 32'd0))
        else $error("match without full window or with zero count");

    // A rejected pattern byte never reports window state
    a_ovf_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[34] |-> !m_tdata[33] && !m_tdata[0])
        else $error("overflow mixed with text result");

    // Reset empties the output stage
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind rolling_hash_pattern_counter_unit rhpc_checker u_rhpc_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rhpc_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 800000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned PRINT_CAP   = 40;

    typedef enum logic {
        MODE_PATTERN = 1'b0,
        MODE_TEXT    = 1'b1
    } word_kind_t;

    typedef struct {
        word_kind_t       kind;
        logic [SYM_W-1:0] sym;
        logic             first;
    } pending_word_t;

    // clock, reset and DUT ports; every input is known from time zero
    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_tvalid  = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata   = '0;   // symbol[7:0]
    logic [1:0]         s_tuser   = '0;   // mode[0], first[1]
    logic               m_tvalid;
    logic               m_tready  = 1'b0;
    logic [39:0]        m_tdata;          // match, match_count, window_full, overflow
    logic               cfg_we    = 1'b0;
    logic [HASH_W-1:0]  cfg_wdata = '0;

    // stimulus and scoreboard
    pending_word_t      words_pending [$];
    result_t            verdicts_due [$];
    int unsigned        words_queued = 0;
    int unsigned        words_taken  = 0;
    int unsigned        results_seen = 0;
    int unsigned        fault_count  = 0;
    int unsigned        cycle_count  = 0;
    int unsigned        send_gap     = 0;
    int unsigned        ready_gap    = 0;
    logic               gaps_on      = 1'b1;
    logic               sink_hold    = 1'b0;
    logic               pressure_go  = 1'b0;

    // hash tracking state, mirrors the block
    logic [HASH_W-1:0]  mult_cfg  = MULT_RESET;
    logic [HASH_W-1:0]  pat_hash  = '0;
    logic [8:0]         pat_len   = '0;
    logic [HASH_W-1:0]  mult_pow  = HASH_W'(1);
    logic [HASH_W-1:0]  win_hash  = '0;
    logic [8:0]         fill      = '0;
    logic [8:0]         ring      = '0;
    logic [COUNT_W-1:0] hit_total = '0;
    logic [SYM_W-1:0]   window_mem [RHPC_MAX_PATTERN];

    rolling_hash_pattern_counter_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // product modulo 2^31
    function automatic logic [HASH_W-1:0] hash_mul(input logic [HASH_W-1:0] x,
                                                   input logic [HASH_W-1:0] y);
        logic [63:0] wide;
        wide = 64'(x) * 64'(y);
        return wide[HASH_W-1:0];
    endfunction

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(6, 40);
    endfunction

    // advance the hash state by one accepted word and queue what it must produce
    task automatic roll_hash(input logic kind, input logic [SYM_W-1:0] sym, input logic first);
        result_t     r;
        logic [31:0] acc;
        r = '0;
        if (kind == MODE_PATTERN) begin
            if (first) begin
                pat_hash = '0;
                pat_len  = '0;
                mult_pow = HASH_W'(1);
            end
            if (pat_len < RHPC_MAX_PATTERN) begin
                pat_hash = hash_mul(pat_hash, mult_cfg) + HASH_W'(sym);
                mult_pow = hash_mul(mult_pow, mult_cfg);
                pat_len  = pat_len + 1'b1;
            end else begin
                r.overflow = 1'b1;   // capacity reached, drop the byte
            end
            // any pattern byte empties the text window
            win_hash = '0;
            fill     = '0;
            ring     = '0;
        end else begin
            if (first) begin
                win_hash  = '0;
                fill      = '0;
                ring      = '0;
                hit_total = '0;
            end
            // an empty pattern discards text bytes
            if (pat_len != 0) begin
                acc = {1'b0, hash_mul(win_hash, mult_cfg)} + 32'(sym);
                if (ring >= pat_len)
                    ring = '0;
                if (fill >= pat_len)
                    acc = acc - {1'b0, hash_mul(HASH_W'(window_mem[ring[7:0]]), mult_pow)};
                else
                    fill = fill + 1'b1;
                win_hash             = acc[HASH_W-1:0];
                window_mem[ring[7:0]] = sym;
                ring                 = ring + 1'b1;
                if (ring >= pat_len)
                    ring = '0;
                if (fill >= pat_len) begin
                    r.window_full = 1'b1;
                    if (win_hash == pat_hash) begin
                        r.match = 1'b1;
                        if (hit_total != COUNT_MAX)
                            hit_total = hit_total + 1'b1;
                    end
                end
            end
        end
        r.match_count = hit_total;
        verdicts_due.push_back(r);
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= PRINT_CAP)
            $display("mismatch at result %0d: %s", results_seen, msg);
    endtask

    task automatic push_word(input word_kind_t kind, input logic [SYM_W-1:0] sym,
                             input logic first);
        pending_word_t w;
        w.kind  = kind;
        w.sym   = sym;
        w.first = first;
        words_pending.push_back(w);
        words_queued++;
    endtask

    // narrow alphabet raises the hit rate, including collisions
    function automatic logic [SYM_W-1:0] draw_symbol(input bit narrow);
        if (!narrow)
            return SYM_W'($urandom_range(0, 255));
        if ($urandom_range(0, 7) == 0)
            return 8'hff;
        return SYM_W'($urandom_range(0, 3));
    endfunction

    // one pattern, then a text with copies of it spliced between random bytes
    task automatic queue_episode(input int unsigned plen, input int unsigned tlen);
        logic [SYM_W-1:0] pat [$];
        logic [SYM_W-1:0] sym;
        bit               narrow;
        int unsigned      n;
        narrow = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < plen; i++) begin
            sym = draw_symbol(narrow);
            if (i < RHPC_MAX_PATTERN)
                pat.push_back(sym);
            push_word(MODE_PATTERN, sym, i == 0);
        end
        n = 0;
        while (n < tlen) begin
            if ($urandom_range(0, 2) == 0) begin
                foreach (pat[k]) begin
                    push_word(MODE_TEXT, pat[k], n == 0);
                    n++;
                end
            end else begin
                push_word(MODE_TEXT, draw_symbol(narrow), n == 0);
                n++;
            end
        end
    endtask

    // loose words: either kind, random first, pattern bytes landing mid-text
    task automatic queue_noise(input int unsigned count);
        for (int i = 0; i < count; i++)
            push_word(word_kind_t'($urandom_range(0, 1)), SYM_W'($urandom_range(0, 255)),
                      $urandom_range(0, 3) == 0);
    endtask

    task automatic queue_random(input int unsigned budget);
        int unsigned stop_at;
        int unsigned r;
        int unsigned plen;
        stop_at = words_queued + budget;
        while (words_queued < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 15) begin
                queue_noise($urandom_range(1, 6));
            end else begin
                r = $urandom_range(0, 99);
                if (r < 70)
                    plen = $urandom_range(1, 4);
                else if (r < 95)
                    plen = $urandom_range(5, 12);
                else
                    plen = $urandom_range(13, 40);
                queue_episode(plen, $urandom_range(8, 40));
            end
        end
    endtask

    // wait until every queued word is in and every result is out
    task automatic drain_block();
        while (words_taken != words_queued || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    task automatic load_multiplier(input logic [HASH_W-1:0] value);
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        mult_cfg   = value;
    endtask

    // sender: hold a word until taken, then idle for a random gap
    always @(posedge aclk) begin
        pending_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                roll_hash(s_tuser[0], s_tdata, s_tuser[1]);
                words_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (send_gap != 0) begin
                    send_gap <= send_gap - 1;
                    s_tvalid <= 1'b0;
                end else if (words_pending.size() != 0) begin
                    w = words_pending.pop_front();
                    s_tdata  <= w.sym;
                    s_tuser  <= {w.first, w.kind};
                    s_tvalid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver: compare each result word with the oldest expectation
    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = result_t'(m_tdata[34:0]);
                if (verdicts_due.size() == 0) begin
                    note_fault("result word with nothing expected");
                end else begin
                    want = verdicts_due.pop_front();
                    if (got.match !== want.match)
                        note_fault($sformatf("match got %b want %b", got.match, want.match));
                    if (got.match_count !== want.match_count)
                        note_fault($sformatf("match_count got %0d want %0d",
                                             got.match_count, want.match_count));
                    if (got.window_full !== want.window_full)
                        note_fault($sformatf("window_full got %b want %b",
                                             got.window_full, want.window_full));
                    if (got.overflow !== want.overflow)
                        note_fault($sformatf("overflow got %b want %b",
                                             got.overflow, want.overflow));
                end
                results_seen++;
            end
            if (sink_hold) begin
                m_tready <= 1'b0;
            end else if (ready_gap != 0) begin
                ready_gap <= ready_gap - 1;
                m_tready  <= 1'b0;
            end else begin
                m_tready  <= 1'b1;
                ready_gap <= ($urandom_range(0, 3) == 0) ? pick_gap() : 0;
            end
        end
    end

    // long receiver hold-off: the block fills up and must stall its input
    initial begin
        while (!pressure_go)
            @(posedge aclk);
        sink_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        sink_hold <= 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed, reset multiplier: text against an empty pattern is dropped
        push_word(MODE_TEXT, 8'h00, 1'b1);
        push_word(MODE_TEXT, 8'hff, 1'b0);
        push_word(MODE_PATTERN, 8'h00, 1'b1);
        push_word(MODE_PATTERN, 8'hff, 1'b0);
        push_word(MODE_PATTERN, 8'h41, 1'b0);
        push_word(MODE_TEXT, 8'h00, 1'b1);
        push_word(MODE_TEXT, 8'hff, 1'b0);
        push_word(MODE_TEXT, 8'h41, 1'b0);
        push_word(MODE_TEXT, 8'h00, 1'b0);
        push_word(MODE_TEXT, 8'hff, 1'b0);
        push_word(MODE_TEXT, 8'h41, 1'b0);
        // extend the pattern mid-text: window empties, the count is kept
        push_word(MODE_PATTERN, 8'h80, 1'b0);
        push_word(MODE_TEXT, 8'h00, 1'b0);
        push_word(MODE_TEXT, 8'hff, 1'b0);
        push_word(MODE_TEXT, 8'h41, 1'b0);
        push_word(MODE_TEXT, 8'h80, 1'b0);
        // new text clears the count
        push_word(MODE_TEXT, 8'hff, 1'b1);
        // one-byte pattern: every equal byte hits
        push_word(MODE_PATTERN, 8'h7f, 1'b1);
        push_word(MODE_TEXT, 8'h7f, 1'b1);
        push_word(MODE_TEXT, 8'h7f, 1'b0);
        push_word(MODE_TEXT, 8'h80, 1'b0);
        drain_block();

        // multiplier 1: hash is a byte sum, collisions galore
        load_multiplier(HASH_W'(1));
        queue_random(100);
        drain_block();

        // largest multiplier, no idling on either side
        gaps_on <= 1'b0;
        load_multiplier(HASH_W'(32'h7fff_ffff));
        queue_random(100);
        drain_block();

        // multiplier 0, with the long receiver stall
        gaps_on <= 1'b1;
        load_multiplier('0);
        queue_random(120);
        pressure_go <= 1'b1;
        drain_block();

        // power of two: the high power wraps to zero
        load_multiplier(HASH_W'(32'h4000_0000));
        queue_random(80);
        drain_block();

        // random multiplier, one pattern past capacity with a full-size window
        load_multiplier(HASH_W'($urandom()));
        queue_episode(RHPC_MAX_PATTERN + 2, RHPC_MAX_PATTERN + 24);
        push_word(MODE_PATTERN, 8'h5a, 1'b0);
        queue_random(60);
        drain_block();

        // back to the reset value
        load_multiplier(MULT_RESET);
        queue_random(60);
        drain_block();

        repeat (8) @(posedge aclk);
        if (fault_count == 0 && verdicts_due.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
